@@ hw/rtl/mp3fhd_pkg.sv @@
// Shared types, constants and lookup tables for the MP3 frame header decoder.
package mp3fhd_pkg;

    // Header field codes
    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [2:0] SYNC_TOP     = 3'b111;
    localparam logic [1:0] VER_MPEG1    = 2'd3;
    localparam logic [1:0] VER_MPEG2    = 2'd2;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] VER_MPEG25   = 2'd0;
    localparam logic [1:0] LAYER_III    = 2'd1;
    localparam logic [3:0] BRI_FREE     = 4'd0;
    localparam logic [3:0] BRI_BAD      = 4'd15;
    localparam logic [1:0] SRI_RESERVED = 2'd3;
    localparam logic [1:0] MODE_MONO    = 2'd3;

    // Result constants
    localparam logic [10:0] SPF_MPEG1    = 11'd1152;
    localparam logic [10:0] SPF_MPEG2    = 11'd576;
    localparam logic [5:0]  SIDE_V1_MONO = 6'd17;
    localparam logic [5:0]  SIDE_V1_STER = 6'd32;
    localparam logic [5:0]  SIDE_V2_MONO = 6'd9;
    localparam logic [5:0]  SIDE_V2_STER = 6'd17;
    localparam logic [5:0]  HDR_BYTES    = 6'd4;
    localparam logic [5:0]  CRC_BYTES    = 6'd2;
    localparam logic [1:0]  CH_MONO      = 2'd1;
    localparam logic [1:0]  CH_STEREO    = 2'd2;

    // Reciprocal of 49 scaled by 2^23, rounded up; exact for numerators below 186413
    localparam int          RECIP_SHIFT = 23;
    localparam logic [17:0] RECIP_49    = 18'd171197;

    // Bitrate tables in kbit/s
    localparam logic [8:0] KBPS_V1 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] KBPS_V2 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    // Base sample rates in hertz
    localparam logic [15:0] BASE_RATE [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

    // Frame length is floor(kbps * scale / divisor); scale per rate index,
    // doubled for MPEG-2.5
    localparam logic [8:0] SCALE_STD [4] = '{9'd160, 9'd3, 9'd9, 9'd0};
    localparam logic [8:0] SCALE_V25 [4] = '{9'd320, 9'd6, 9'd18, 9'd0};

    typedef enum logic [1:0] {
        DIV_ONE = 2'd0,
        DIV_TWO = 2'd1,
        DIV_49  = 2'd2
    } div_sel_t;

    // Fields that ride along the whole pipeline
    typedef struct packed {
        logic        rej;
        logic [1:0]  version;
        logic        crc;
        logic [15:0] rate;
        logic        mono;
        logic        mpeg1;
        logic        pad;
        div_sel_t    div_sel;
    } hdr_info_t;

    // First stage beat
    typedef struct packed {
        hdr_info_t   info;
        logic [8:0]  kbps;
        logic [8:0]  scale;
    } parse_beat_t;

endpackage

@@ hw/rtl/mp3fhd_hdr_parse.sv @@
// First pipeline stage: sync and field checks, bitrate and sample-rate lookup.
module mp3fhd_hdr_parse
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [31:0]             hdr_word,
    output logic                    beat_vld,
    output mp3fhd_pkg::parse_beat_t beat
);
    import mp3fhd_pkg::*;

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [1:0]  ver;
    logic [1:0]  layer;
    logic [3:0]  bri;
    logic [1:0]  sri;
    logic        mpeg1;
    logic [15:0] base;
    logic        vld_reg;
    logic        vld_next;
    parse_beat_t beat_reg;
    parse_beat_t beat_next;

    assign b0    = hdr_word[31:24];
    assign b1    = hdr_word[23:16];
    assign b2    = hdr_word[15:8];
    assign b3    = hdr_word[7:0];
    assign ver   = b1[4:3];
    assign layer = b1[2:1];
    assign bri   = b2[7:4];
    assign sri   = b2[3:2];
    assign mpeg1 = (ver == VER_MPEG1);
    assign base  = BASE_RATE[sri];

    // Decode the header fields
    always_comb
    begin
        beat_next.info.rej = (b0 != SYNC_BYTE) || (b1[7:5] != SYNC_TOP)
                             || (ver == VER_RESERVED) || (layer != LAYER_III)
                             || (bri == BRI_FREE) || (bri == BRI_BAD)
                             || (sri == SRI_RESERVED);
        beat_next.info.version = ver;
        beat_next.info.crc     = ~b1[0];
        beat_next.info.mono    = (b3[7:6] == MODE_MONO);
        beat_next.info.mpeg1   = mpeg1;
        beat_next.info.pad     = b2[1];
        unique case (ver)
            VER_MPEG2:  beat_next.info.rate = {1'b0, base[15:1]};
            VER_MPEG25: beat_next.info.rate = {2'b00, base[15:2]};
            default:    beat_next.info.rate = base;
        endcase
        unique case (sri)
            2'd0:    beat_next.info.div_sel = DIV_49;
            2'd2:    beat_next.info.div_sel = DIV_TWO;
            default: beat_next.info.div_sel = DIV_ONE;
        endcase
        beat_next.kbps  = mpeg1 ? KBPS_V1[bri] : KBPS_V2[bri];
        beat_next.scale = (ver == VER_MPEG25) ? SCALE_V25[sri] : SCALE_STD[sri];
    end

    assign vld_next = accept;

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Hold the decoded beat
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign beat_vld = vld_reg;
    assign beat     = beat_reg;

endmodule

@@ hw/rtl/mp3_frame_header_decode.sv @@
// Top level of the MP3 frame header decoder: frame length pipeline and result registers.
//
// Usage: drive header_word with four header bytes (first byte in bits 31..24)
// and pulse start. busy is tied low, so a header is taken on every cycle that
// start is high; one header may enter each clock.
// Each header gives exactly one result, shown for one cycle with done high.
// Throughput is one header per cycle. Each header passes through four
// register stages: field decode and table lookup, bitrate scaling
// multiply, multiply by the reciprocal of 49, and the final quotient
// select, padding add and length check.
// A rejected header (bad sync, reserved version, not Layer III, free-format
// or illegal bitrate, reserved sample rate) returns all fields zero. A header
// whose frame is too short for header, CRC and side information returns
// valid_res low with the decoded fields.
// Reset clears the stage valid bits, so no result appears after reset until
// a new header is taken. The receiver cannot stall: done is a strobe and
// the result must be captured in the cycle it is shown.
module mp3_frame_header_decode
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] header_word,
    output logic        done,
    output logic        valid_res,
    output logic [1:0]  version,
    output logic        crc_present,
    output logic [15:0] sample_rate,
    output logic [1:0]  channel_count,
    output logic [10:0] samples_per_frame,
    output logic [10:0] frame_bytes,
    output logic [5:0]  side_info_bytes
);
    import mp3fhd_pkg::*;

    logic        accept;
    logic        s1_vld;
    parse_beat_t s1_beat;

    logic        s2_vld_reg;
    logic        s2_vld_next;
    hdr_info_t   s2_info_reg;
    logic [15:0] s2_num_reg;
    logic [15:0] s2_num_next;

    logic        s3_vld_reg;
    hdr_info_t   s3_info_reg;
    logic [15:0] s3_num_reg;
    logic [33:0] s3_prod_reg;
    logic [33:0] s3_prod_next;

    logic [10:0] quot;
    logic [10:0] bytes;
    logic [5:0]  side;
    logic [5:0]  thresh;

    logic        done_reg;
    logic        valid_res_reg;
    logic        valid_res_next;
    logic [1:0]  version_reg;
    logic [1:0]  version_next;
    logic        crc_reg;
    logic        crc_next;
    logic [15:0] rate_reg;
    logic [15:0] rate_next;
    logic [1:0]  chan_reg;
    logic [1:0]  chan_next;
    logic [10:0] spf_reg;
    logic [10:0] spf_next;
    logic [10:0] bytes_reg;
    logic [10:0] bytes_next;
    logic [5:0]  side_reg;
    logic [5:0]  side_next;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    mp3fhd_hdr_parse u_parse
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .hdr_word (header_word),
        .beat_vld (s1_vld),
        .beat     (s1_beat)
    );

    // Scale the bitrate
    assign s2_vld_next = s1_vld;
    assign s2_num_next = 16'({9'd0, s1_beat.kbps} * {9'd0, s1_beat.scale});

    // Multiply by the reciprocal of 49
    assign s3_prod_next = s2_num_reg * RECIP_49;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s2_vld_reg;
            done_reg   <= s3_vld_reg;
        end
    end

    // Hold the payload of each stage
    always_ff @(posedge clk)
    begin
        s2_info_reg   <= s1_beat.info;
        s2_num_reg    <= s2_num_next;
        s3_info_reg   <= s2_info_reg;
        s3_num_reg    <= s2_num_reg;
        s3_prod_reg   <= s3_prod_next;
        valid_res_reg <= valid_res_next;
        version_reg   <= version_next;
        crc_reg       <= crc_next;
        rate_reg      <= rate_next;
        chan_reg      <= chan_next;
        spf_reg       <= spf_next;
        bytes_reg     <= bytes_next;
        side_reg      <= side_next;
    end

    // Pick the quotient, add padding, check the frame is long enough
    always_comb
    begin
        unique case (s3_info_reg.div_sel)
            DIV_49:  quot = s3_prod_reg[RECIP_SHIFT +: 11];
            DIV_TWO: quot = s3_num_reg[11:1];
            default: quot = s3_num_reg[10:0];
        endcase
        bytes = quot + {10'd0, s3_info_reg.pad};
        if (s3_info_reg.mpeg1)
        begin
            side = s3_info_reg.mono ? SIDE_V1_MONO : SIDE_V1_STER;
        end
        else
        begin
            side = s3_info_reg.mono ? SIDE_V2_MONO : SIDE_V2_STER;
        end
        thresh = HDR_BYTES + (s3_info_reg.crc ? CRC_BYTES : 6'd0) + side;

        if (s3_info_reg.rej)
        begin
            valid_res_next = 1'b0;
            version_next   = 2'd0;
            crc_next       = 1'b0;
            rate_next      = 16'd0;
            chan_next      = 2'd0;
            spf_next       = 11'd0;
            bytes_next     = 11'd0;
            side_next      = 6'd0;
        end
        else
        begin
            valid_res_next = (bytes > {5'd0, thresh});
            version_next   = s3_info_reg.version;
            crc_next       = s3_info_reg.crc;
            rate_next      = s3_info_reg.rate;
            chan_next      = s3_info_reg.mono ? CH_MONO : CH_STEREO;
            spf_next       = s3_info_reg.mpeg1 ? SPF_MPEG1 : SPF_MPEG2;
            bytes_next     = bytes;
            side_next      = side;
        end
    end

    assign done              = done_reg;
    assign valid_res         = valid_res_reg;
    assign version           = version_reg;
    assign crc_present       = crc_reg;
    assign sample_rate       = rate_reg;
    assign channel_count     = chan_reg;
    assign samples_per_frame = spf_reg;
    assign frame_bytes       = bytes_reg;
    assign side_info_bytes   = side_reg;

endmodule

@@ hw/rtl/mp3fhd_checker.sv @@
// Port-level checker for the MP3 frame header decoder, with its bind.
module mp3fhd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        valid_res,
    input logic [1:0]  version,
    input logic [15:0] sample_rate,
    input logic [1:0]  channel_count,
    input logic [10:0] frame_bytes,
    input logic [5:0]  side_info_bytes
);
    import mp3fhd_pkg::*;

    // Every taken header gives a result beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##4 done)
        else $error("result beat missing after accepted header");

    // No result beat without a matching taken header
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result beat without a matching header");

    // A usable header has a frame longer than header plus side information and a non-zero sample rate
    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && valid_res |-> (frame_bytes > {5'd0, side_info_bytes} + 11'd4)
                              && (sample_rate != 16'd0))
        else $error("valid header with impossible frame length");

    // Rejected headers (zero channel count) read zero in valid_res, version, frame length and sample rate
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (channel_count == 2'd0) |-> !valid_res && (version == 2'd0)
                                            && (frame_bytes == 11'd0)
                                            && (sample_rate == 16'd0))
        else $error("rejected header with non-zero fields");

endmodule

bind mp3_frame_header_decode mp3fhd_checker u_mp3fhd_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .valid_res       (valid_res),
    .version         (version),
    .sample_rate     (sample_rate),
    .channel_count   (channel_count),
    .frame_bytes     (frame_bytes),
    .side_info_bytes (side_info_bytes)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the MP3 frame header decoder: directed and random header beats.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mp3fhd_pkg::*;

    localparam int unsigned DRAIN_SLACK = 8;       // pipeline is four stages deep
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PRINT_CAP   = 40;

    // Own copies of the bitrate and base rate tables
    localparam int unsigned MPEG1_KBPS [16] = '{0, 32, 40, 48, 56, 64, 80, 96,
                                                112, 128, 160, 192, 224, 256, 320, 0};
    localparam int unsigned MPEG2_KBPS [16] = '{0, 8, 16, 24, 32, 40, 48, 56,
                                                64, 80, 96, 112, 128, 144, 160, 0};
    localparam int unsigned BASE_HZ [4] = '{44100, 48000, 32000, 0};

    typedef struct packed {
        logic        valid;
        logic [1:0]  ver;
        logic        crc;
        logic [15:0] rate;
        logic [1:0]  chans;
        logic [10:0] spf;
        logic [10:0] bytes;
        logic [5:0]  side;
    } frame_info_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] header_word = '0;
    logic        busy;
    logic        done;
    logic        valid_res;
    logic [1:0]  version;
    logic        crc_present;
    logic [15:0] sample_rate;
    logic [1:0]  channel_count;
    logic [10:0] samples_per_frame;
    logic [10:0] frame_bytes;
    logic [5:0]  side_info_bytes;

    frame_info_t pending_frames[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned usable_count = 0;
    int unsigned refused_count = 0;
    int unsigned version_count [4] = '{0, 0, 0, 0};

    mp3_frame_header_decode dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .header_word       (header_word),
        .done              (done),
        .valid_res         (valid_res),
        .version           (version),
        .crc_present       (crc_present),
        .sample_rate       (sample_rate),
        .channel_count     (channel_count),
        .samples_per_frame (samples_per_frame),
        .frame_bytes       (frame_bytes),
        .side_info_bytes   (side_info_bytes)
    );

    always #1 clk = ~clk;

    // Decode one header word as Layer III; refused headers read all zero
    function automatic frame_info_t decode_header(logic [31:0] w);
        frame_info_t r;
        logic [1:0]  ver;
        logic [1:0]  layer;
        logic [1:0]  sri;
        logic [3:0]  bri;
        logic        mpeg1;
        logic        mono;
        logic        crc;
        int unsigned kbps;
        int unsigned rate;
        int unsigned coef;
        int unsigned bytes;
        int unsigned side;
        r = '0;
        if (w[31:24] != SYNC_BYTE || w[23:21] != SYNC_TOP)
            return r;
        ver   = w[20:19];
        layer = w[18:17];
        bri   = w[15:12];
        sri   = w[11:10];
        if (ver == VER_RESERVED || layer != LAYER_III || bri == BRI_FREE ||
            bri == BRI_BAD || sri == SRI_RESERVED)
            return r;
        mpeg1 = (ver == VER_MPEG1);
        kbps  = mpeg1 ? MPEG1_KBPS[bri] : MPEG2_KBPS[bri];
        rate  = BASE_HZ[sri];
        if (ver == VER_MPEG2)
            rate = rate / 2;
        if (ver == VER_MPEG25)
            rate = rate / 4;
        mono  = (w[7:6] == MODE_MONO);
        crc   = ~w[16];
        coef  = mpeg1 ? 144 : 72;
        bytes = coef * kbps * 1000 / rate + w[9];
        side  = mpeg1 ? (mono ? 17 : 32) : (mono ? 9 : 17);
        r.valid = bytes > 4 + (crc ? 2 : 0) + side;
        r.ver   = ver;
        r.crc   = crc;
        r.rate  = rate[15:0];
        r.chans = mono ? 2'd1 : 2'd2;
        r.spf   = mpeg1 ? 11'd1152 : 11'd576;
        r.bytes = bytes[10:0];
        r.side  = side[5:0];
        return r;
    endfunction

    // Assemble a header with sync in place and random private, extension and emphasis bits
    function automatic logic [31:0] build_header(logic [1:0] ver, logic [1:0] layer,
                                                 logic [3:0] bri, logic [1:0] sri,
                                                 logic pad, logic prot, logic [1:0] mode);
        logic       priv;
        logic [5:0] tail;
        priv = 1'($urandom_range(1));
        tail = 6'($urandom());
        return {SYNC_BYTE, SYNC_TOP, ver, layer, prot, bri, sri, pad, priv, mode, tail};
    endfunction

    // Well-formed Layer III header with random content
    function automatic logic [31:0] random_good_header();
        logic [1:0] ver;
        case ($urandom_range(2))
            0: ver = VER_MPEG1;
            1: ver = VER_MPEG2;
            default: ver = VER_MPEG25;
        endcase
        return build_header(ver, LAYER_III, 4'($urandom_range(1, 14)), 2'($urandom_range(2)),
                            1'($urandom_range(1)), 1'($urandom_range(1)), 2'($urandom_range(3)));
    endfunction

    // Well-formed header with at most one field broken
    function automatic logic [31:0] random_broken_header();
        logic [31:0] w;
        logic [1:0]  layer;
        w = random_good_header();
        case ($urandom_range(4))
            0: w[$urandom_range(21, 31)] = ~w[$urandom_range(21, 31)];
            1: w[20:19] = VER_RESERVED;
            2:
            begin
                layer = 2'($urandom_range(2));
                w[18:17] = (layer == LAYER_III) ? 2'd3 : layer;
            end
            3: w[15:12] = $urandom_range(1) ? BRI_FREE : BRI_BAD;
            default: w[11:10] = SRI_RESERVED;
        endcase
        return w;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("ERROR result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    endtask

    // Send one header beat and hold it until taken; log its expected decode
    task automatic send_header(logic [31:0] word);
        frame_info_t want;
        start       <= 1'b1;
        header_word <= word;
        do
            @(posedge clk);
        while (busy);
        want = decode_header(word);
        pending_frames.insert(pending_frames.size(), want);
        if (want.valid)
        begin
            usable_count++;
            version_count[want.ver]++;
        end
        else
            refused_count++;
    endtask

    // Drop start for a number of cycles with junk on the header bus
    task automatic sender_gap(int unsigned cycles);
        if (cycles > 0)
        begin
            start       <= 1'b0;
            header_word <= $urandom();
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Hold off until every outstanding result has arrived, then let the pipe settle
    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Compare each result beat against the oldest expectation
    always @(posedge clk)
    begin
        frame_info_t want;
        if (done)
        begin
            results_seen++;
            if (pending_frames.size() == 0)
                report_mismatch("unexpected result, frame_bytes", frame_bytes, 0);
            else
            begin
                want = pending_frames.pop_front();
                if (valid_res !== want.valid)
                    report_mismatch("valid_res", valid_res, want.valid);
                if (version !== want.ver)
                    report_mismatch("version", version, want.ver);
                if (crc_present !== want.crc)
                    report_mismatch("crc_present", crc_present, want.crc);
                if (sample_rate !== want.rate)
                    report_mismatch("sample_rate", sample_rate, want.rate);
                if (channel_count !== want.chans)
                    report_mismatch("channel_count", channel_count, want.chans);
                if (samples_per_frame !== want.spf)
                    report_mismatch("samples_per_frame", samples_per_frame, want.spf);
                if (frame_bytes !== want.bytes)
                    report_mismatch("frame_bytes", frame_bytes, want.bytes);
                if (side_info_bytes !== want.side)
                    report_mismatch("side_info_bytes", side_info_bytes, want.side);
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("mp3_frame_header_decode: mismatch");
            $finish;
        end
    end

    // Every way a header is refused, plus all-zero and all-one words
    task automatic test_rejections();
        send_header(32'h0000_0000);
        send_header(32'hFFFF_FFFF);
        send_header(build_header(VER_MPEG1, LAYER_III, 4'd9, 2'd0, 1'b0, 1'b1, 2'd0)
                    & 32'hFEFF_FFFF);
        send_header(build_header(VER_MPEG1, LAYER_III, 4'd9, 2'd0, 1'b0, 1'b1, 2'd0)
                    & 32'hFF1F_FFFF);
        send_header(build_header(VER_RESERVED, LAYER_III, 4'd9, 2'd0, 1'b0, 1'b1, 2'd0));
        send_header(build_header(VER_MPEG1, 2'd0, 4'd9, 2'd0, 1'b0, 1'b1, 2'd0));
        send_header(build_header(VER_MPEG2, 2'd2, 4'd9, 2'd1, 1'b0, 1'b1, 2'd1));
        send_header(build_header(VER_MPEG25, 2'd3, 4'd9, 2'd2, 1'b0, 1'b1, 2'd2));
        send_header(build_header(VER_MPEG1, LAYER_III, BRI_FREE, 2'd0, 1'b1, 1'b0, 2'd0));
        send_header(build_header(VER_MPEG2, LAYER_III, BRI_BAD, 2'd0, 1'b1, 1'b0, 2'd0));
        send_header(build_header(VER_MPEG25, LAYER_III, 4'd5, SRI_RESERVED, 1'b1, 1'b0, 2'd3));
        wait_all_results();
    endtask

    // Longest and shortest frames per version, mono and stereo, CRC on and off
    task automatic test_frame_extremes();
        send_header(build_header(VER_MPEG1, LAYER_III, 4'd14, 2'd2, 1'b1, 1'b1, 2'd0));
        send_header(build_header(VER_MPEG1, LAYER_III, 4'd1, 2'd1, 1'b0, 1'b0, MODE_MONO));
        send_header(build_header(VER_MPEG1, LAYER_III, 4'd9, 2'd0, 1'b1, 1'b1, 2'd1));
        send_header(build_header(VER_MPEG1, LAYER_III, 4'd1, 2'd1, 1'b0, 1'b0, 2'd2));
        send_header(build_header(VER_MPEG2, LAYER_III, 4'd14, 2'd2, 1'b1, 1'b1, 2'd1));
        // shortest frame that still clears header, CRC and stereo side information
        send_header(build_header(VER_MPEG2, LAYER_III, 4'd1, 2'd1, 1'b0, 1'b0, 2'd0));
        send_header(build_header(VER_MPEG2, LAYER_III, 4'd1, 2'd1, 1'b0, 1'b0, MODE_MONO));
        send_header(build_header(VER_MPEG25, LAYER_III, 4'd14, 2'd2, 1'b1, 1'b1, 2'd2));
        send_header(build_header(VER_MPEG25, LAYER_III, 4'd1, 2'd1, 1'b0, 1'b0, MODE_MONO));
        send_header(build_header(VER_MPEG25, LAYER_III, 4'd7, 2'd0, 1'b1, 1'b0, 2'd0));
        wait_all_results();
    endtask

    // Mostly well-formed headers, some broken, some noise, with sender gaps at the given idle percentage
    task automatic test_random(int unsigned items, int unsigned idle_pct);
        logic [31:0] w;
        int unsigned pick;
        for (int unsigned k = 0; k < items; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                w = random_good_header();
            else if (pick < 90)
                w = random_broken_header();
            else
                w = $urandom();
            send_header(w);
            if ($urandom_range(99) < idle_pct)
                sender_gap($urandom_range(1, 5));
            if (k % 150 == 149)
                wait_all_results();
        end
        wait_all_results();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rejections();
        test_frame_extremes();
        test_random(400, 22);
        test_random(400, 55);
        test_random(300, 0);

        if (pending_frames.size() != 0)
            report_mismatch("results never seen", 0, pending_frames.size());

        $display("%0d headers decoded: %0d usable, %0d refused", results_seen,
                 usable_count, refused_count);
        $display("usable by version: MPEG-1 %0d, MPEG-2 %0d, MPEG-2.5 %0d; %0d mismatches",
                 version_count[VER_MPEG1], version_count[VER_MPEG2],
                 version_count[VER_MPEG25], mismatch_count);
        if (mismatch_count == 0)
            $display("mp3_frame_header_decode: match");
        else
            $display("mp3_frame_header_decode: mismatch");
        $finish;
    end

endmodule

@@ mp3_frame_header_decode.f @@
hw/rtl/mp3fhd_pkg.sv
hw/rtl/mp3fhd_hdr_parse.sv
hw/rtl/mp3_frame_header_decode.sv
hw/rtl/mp3fhd_checker.sv
dv/tb_top.sv
